// File: hdl/fgs_pkg.sv
// Shared types, constants and the rule-table decode for the 7x7 fuzzy gain scheduler.
// Used by every module of the block; depends on nothing.
package fgs_pkg;

  // Default fraction bits of the Q-format inputs and result.
  localparam int FRAC_BITS_DEF = 12;

  // Field and table geometry.
  localparam int IN_W      = 16;
  localparam int OUT_W     = 15;
  localparam int NUM_SETS  = 7;
  localparam int SET_W     = 3;
  localparam int CODE_W    = 3;
  localparam int RULE_W    = NUM_SETS * CODE_W;
  localparam int CFG_IDX_W = 3;

  // Rule code decode: value is code minus the bias, the top code saturates.
  localparam logic [CODE_W-1:0] CODE_BIAS = 3'd3;
  localparam logic [CODE_W-1:0] CODE_SAT  = 3'd7;
  localparam logic signed [CODE_W-1:0] RULE_MAX  = 3'sd3;
  localparam logic signed [CODE_W-1:0] RULE_NONE = 3'sd0;

  typedef logic [NUM_SETS-1:0][RULE_W-1:0] rule_rows_t;

  // Four signed rule values, one per (error set, rate set) pair: index 2*a+b.
  typedef logic [3:0][CODE_W-1:0] rule_quad_t;

  localparam rule_rows_t RULE_RESET = {
    21'd1792814, 21'd1792813, 21'd1493221, 21'd599186,
    21'd1456429, 21'd1493878, 21'd1756022
  };

  // Signed rule value for error set r and rate set c. A set index past the
  // last set only occurs with a zero grade, so it reads as zero.
  function automatic logic signed [CODE_W-1:0] rule_value(
    input rule_rows_t        rows,
    input logic [SET_W-1:0]  r,
    input logic [SET_W-1:0]  c
  );
    logic [CODE_W-1:0] code;
    logic [RULE_W-1:0] row;
    code = CODE_BIAS;
    row  = '0;
    if ((int'(r) < NUM_SETS) && (int'(c) < NUM_SETS)) begin
      row  = rows[r];
      code = row[int'(c) * CODE_W +: CODE_W];
    end
    if (code == CODE_SAT) begin
      return RULE_MAX;
    end
    return signed'(CODE_W'(code - CODE_BIAS));
  endfunction

endpackage

// File: hdl/fgs_fuzzify.sv
// First pipeline stage: clamps error and rate to plus or minus 3 and splits
// each into a base set index and the two triangle grades. Uses fgs_pkg.
module fgs_fuzzify
  import fgs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] error_in,
  input  logic signed [IN_W-1:0] error_rate_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0][SET_W-1:0]  base_idx,   // [0] error, [1] rate
  output logic [1:0][FRAC_BITS:0] grade_lo,  // grade of the base set
  output logic [1:0][FRAC_BITS:0] grade_hi   // grade of the next set up
);

  localparam int XW = (FRAC_BITS + 4 > IN_W + 1) ? FRAC_BITS + 4 : IN_W + 1;
  localparam logic signed [XW-1:0] LIM_P = XW'(3 << FRAC_BITS);
  localparam logic signed [XW-1:0] LIM_N = -LIM_P;
  localparam logic [FRAC_BITS:0] GRADE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic signed [IN_W-1:0]     raw [2];
  logic signed [XW-1:0]       x [2];
  logic signed [XW-1:0]       xc [2];
  logic signed [XW-1:0]       u [2];
  logic [1:0][SET_W-1:0]      idx_next;
  logic [1:0][FRAC_BITS:0]    lo_next;
  logic [1:0][FRAC_BITS:0]    hi_next;

  assign raw[0] = error_in;
  assign raw[1] = error_rate_in;

  // Clamp, shift to [0, 6S] and split into set index and fraction.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      x[g]  = {{(XW-IN_W){raw[g][IN_W-1]}}, raw[g]};
      xc[g] = (x[g] > LIM_P) ? LIM_P : ((x[g] < LIM_N) ? LIM_N : x[g]);
      u[g]  = xc[g] + LIM_P;
      idx_next[g] = u[g][FRAC_BITS +: SET_W];
      hi_next[g]  = {1'b0, u[g][FRAC_BITS-1:0]};
      lo_next[g]  = GRADE_ONE - {1'b0, u[g][FRAC_BITS-1:0]};
    end
  end

  // Stage register with its valid bit.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      base_idx <= idx_next;
      grade_lo <= lo_next;
      grade_hi <= hi_next;
    end
  end

endmodule

// File: hdl/fgs_weight.sv
// Second and third pipeline stages: grade products with the rule lookup, then
// each product weighted by its signed rule value. Uses fgs_pkg.
module fgs_weight
  import fgs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TW        = 2 * FRAC_BITS + 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rule_rows_t              rule_rows,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0][SET_W-1:0]   base_idx,
  input  logic [1:0][FRAC_BITS:0] grade_lo,
  input  logic [1:0][FRAC_BITS:0] grade_hi,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0][TW-1:0]      terms      // signed, pair index 2*a+b
);

  localparam int PW = 2 * FRAC_BITS + 2;

  logic                  prod_valid;
  logic                  prod_ready;
  logic                  in_ready_w;
  logic [3:0][PW-1:0]    prod;
  rule_quad_t            rules;
  logic [3:0][PW-1:0]    prod_next;
  rule_quad_t            rules_next;
  logic [1:0][FRAC_BITS:0] ge;
  logic [1:0][FRAC_BITS:0] gd;
  logic [1:0][SET_W-1:0]   es;
  logic [1:0][SET_W-1:0]   ds;

  // Grade products and rule values for the four set pairs.
  always_comb begin
    ge = {grade_hi[0], grade_lo[0]};
    gd = {grade_hi[1], grade_lo[1]};
    es = {base_idx[0] + SET_W'(1), base_idx[0]};
    ds = {base_idx[1] + SET_W'(1), base_idx[1]};
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        prod_next[2*a+b]  = PW'(ge[a] * gd[b]);
        rules_next[2*a+b] = rule_value(rule_rows, es[a], ds[b]);
      end
    end
  end

  assign prod_ready = !prod_valid || in_ready_w;
  assign in_ready   = prod_ready;

  assign in_ready_w = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      prod  <= prod_next;
      rules <= rules_next;
    end
  end

  // Weight each product by its rule value (a small signed multiply).
  logic [3:0][TW-1:0] terms_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      terms_next[k] = TW'(signed'({{(TW-PW){1'b0}}, prod[k]})
                      * signed'({{(TW-CODE_W){rules[k][CODE_W-1]}}, rules[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready_w) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready_w && prod_valid) begin
      terms <= terms_next;
    end
  end

endmodule

// File: hdl/fgs_defuzz.sv
// Last three pipeline stages: sum of the weighted terms, magnitude, then
// rounding to nearest with ties away from zero. Uses fgs_pkg.
module fgs_defuzz
  import fgs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TW        = 2 * FRAC_BITS + 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0][TW-1:0]      terms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_W-1:0]        gain_adjust
);

  localparam int QW = TW - FRAC_BITS;
  localparam int RW = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
  localparam logic [TW-2:0] HALF  = (TW-1)'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] Q_MAX = QW'(3) << FRAC_BITS;

  logic                 sum_valid;
  logic                 sum_ready;
  logic signed [TW-1:0] num;
  logic                 mag_valid;
  logic                 mag_ready;
  logic                 neg;
  logic [TW-2:0]        mag;
  logic [TW-2:0]        rounded;
  logic [QW-1:0]        q;
  logic [QW-1:0]        q_sat;
  logic signed [RW-1:0] q_signed;

  assign in_ready  = !sum_valid || sum_ready;
  assign sum_ready = !mag_valid || mag_ready;
  assign mag_ready = !out_valid || out_ready;

  // Sum of the four weighted terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (in_ready) begin
      sum_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num <= signed'(terms[0]) + signed'(terms[1])
           + signed'(terms[2]) + signed'(terms[3]);
    end
  end

  // Sign and magnitude of the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (sum_ready) begin
      mag_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      neg <= num[TW-1];
      mag <= num[TW-1] ? (TW-1)'(-num) : num[TW-2:0];
    end
  end

  // Round the magnitude, saturate to 3, restore the sign.
  always_comb begin
    rounded  = mag + HALF;
    q        = QW'(rounded >> FRAC_BITS);
    q_sat    = (q > Q_MAX) ? Q_MAX : q;
    q_signed = neg ? -signed'(RW'(q_sat)) : signed'(RW'(q_sat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mag_ready) begin
      out_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && mag_valid) begin
      gain_adjust <= q_signed[OUT_W-1:0];
    end
  end

endmodule

// File: hdl/fuzzy_gain_scheduler_7x7.sv
// Top level of the 7x7 fuzzy gain scheduler: rule table registers and the
// six-stage datapath. Uses fgs_pkg, fgs_fuzzify, fgs_weight and fgs_defuzz.
//
// Usage:
//   Each request on the s_t* stream carries an error and an error rate in
//   signed fixed point with FRAC_BITS fraction bits. The block returns one
//   result on the m_t* stream per request: the grade-weighted average of the
//   7x7 rule table, same format, within plus or minus 3.
//   The rule table sits in seven 21-bit row registers written through the
//   cfg_* channel (cfg_index 0..6; higher indexes are ignored). cfg_ready is
//   always high. The user must write rows only while no request is in flight; the block does not enforce it.
//   Throughput is one request per cycle while the receiver keeps m_tready
//   high; the six register stages each hold one request, the grade
//   multipliers sit in the second stage.
//   Reset loads the default rule table and empties the pipeline.
//   When the receiver holds m_tready low, results stay in the output
//   register and the stages behind it keep filling their empty slots;
//   s_tready drops only once every stage holds a request.
module fuzzy_gain_scheduler_7x7
  import fgs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*IN_W-1:0]    s_tdata,   // [15:0] error_in, [31:16] error_rate_in
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W:0]       m_tdata,   // [14:0] gain_adjust, [15] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RULE_W-1:0]    cfg_data
);

  localparam int TW = 2 * FRAC_BITS + 5;

  rule_rows_t                rule_rows;
  logic                      fz_valid;
  logic                      fz_ready;
  logic [1:0][SET_W-1:0]     base_idx;
  logic [1:0][FRAC_BITS:0]   grade_lo;
  logic [1:0][FRAC_BITS:0]   grade_hi;
  logic                      wt_valid;
  logic                      wt_ready;
  logic [3:0][TW-1:0]        terms;
  logic [OUT_W-1:0]          gain_adjust;

  // Rule table row registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_rows <= RULE_RESET;
    end else if (cfg_valid && (int'(cfg_index) < NUM_SETS)) begin
      rule_rows[cfg_index] <= cfg_data;
    end
  end

  // Datapath stages.
  fgs_fuzzify #(.FRAC_BITS(FRAC_BITS)) u_fuzzify (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .error_in      (signed'(s_tdata[IN_W-1:0])),
    .error_rate_in (signed'(s_tdata[2*IN_W-1:IN_W])),
    .out_valid     (fz_valid),
    .out_ready     (fz_ready),
    .base_idx      (base_idx),
    .grade_lo      (grade_lo),
    .grade_hi      (grade_hi)
  );

  fgs_weight #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_weight (
    .clk       (clk),
    .rst       (rst),
    .rule_rows (rule_rows),
    .in_valid  (fz_valid),
    .in_ready  (fz_ready),
    .base_idx  (base_idx),
    .grade_lo  (grade_lo),
    .grade_hi  (grade_hi),
    .out_valid (wt_valid),
    .out_ready (wt_ready),
    .terms     (terms)
  );

  fgs_defuzz #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_defuzz (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (wt_valid),
    .in_ready    (wt_ready),
    .terms       (terms),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .gain_adjust (gain_adjust)
  );

  assign m_tdata = {1'b0, gain_adjust};

  // A ready receiver never stalls the input side.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the receiver is ready");

  // The input side stalls only behind a held result.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held result");

  // A write to a table row lands in that row.
  a_row_written: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_SETS)))
    |=> (rule_rows[$past(cfg_index)] == $past(cfg_data)))
    else $error("rule row write lost");

  // A write past the last row leaves the table alone.
  a_bad_index_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index >= CFG_IDX_W'(NUM_SETS)))
    |=> $stable(rule_rows))
    else $error("rule table changed by an out-of-range write");

endmodule

// File: sim/fgs_checker.sv
// Scoreboard for the 7x7 fuzzy gain scheduler: tracks rule-row writes, predicts
// each gain from an accepted request and compares it with the returned result.
// Depends on fgs_pkg for widths and the reset rule table.
`timescale 1ns / 1ps

module fgs_checker
  import fgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [2*IN_W-1:0]    s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_W:0]       m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RULE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam longint SCALE = longint'(1) << FRAC_BITS_DEF;
  localparam int     REPORT_LIMIT = 10;

  typedef struct {
    logic [IN_W-1:0]  err;
    logic [IN_W-1:0]  rate;
    logic [OUT_W-1:0] gain;
  } gain_expect_t;

  logic [RULE_W-1:0] rule_row_q [NUM_SETS];
  gain_expect_t      gain_expect_q [$];
  int                errors;

  // Clamp a Q.12 input to plus or minus three and split it into the lower
  // active set and the grade of the upper one.
  function automatic void split_input(
    input  logic [IN_W-1:0] raw,
    output int              base,
    output longint          frac
  );
    longint x;
    longint u;
    x = longint'($signed(raw));
    if (x > 3 * SCALE) x = 3 * SCALE;
    if (x < -3 * SCALE) x = -3 * SCALE;
    u = x + 3 * SCALE;
    base = int'(u >>> FRAC_BITS_DEF);
    frac = u & (SCALE - 1);
  endfunction

  // Grade-weighted average over the distinct active (error, rate) set pairs,
  // rounded to nearest with ties away from zero.
  function automatic logic [OUT_W-1:0] blend_gain(
    input logic [IN_W-1:0] err,
    input logic [IN_W-1:0] rate
  );
    int                e_base, r_base, e_n, r_n, value;
    longint            e_frac, r_frac, num, mag;
    int                e_set [2];
    int                r_set [2];
    longint            e_wt [2];
    longint            r_wt [2];
    logic [CODE_W-1:0] code;
    split_input(err, e_base, e_frac);
    split_input(rate, r_base, r_frac);
    e_set[0] = e_base;
    e_wt[0]  = SCALE - e_frac;
    e_n      = 1;
    if (e_frac != 0 && e_base + 1 < NUM_SETS) begin
      e_set[1] = e_base + 1;
      e_wt[1]  = e_frac;
      e_n      = 2;
    end
    r_set[0] = r_base;
    r_wt[0]  = SCALE - r_frac;
    r_n      = 1;
    if (r_frac != 0 && r_base + 1 < NUM_SETS) begin
      r_set[1] = r_base + 1;
      r_wt[1]  = r_frac;
      r_n      = 2;
    end
    num = 0;
    for (int a = 0; a < e_n; a++) begin
      for (int b = 0; b < r_n; b++) begin
        code = rule_row_q[e_set[a]][CODE_W*r_set[b] +: CODE_W];
        // The top code would mean +4; it saturates to +3.
        value = (code == CODE_SAT) ? 3 : int'(code) - int'(CODE_BIAS);
        num += e_wt[a] * r_wt[b] * longint'(value);
      end
    end
    mag = (num < 0) ? -num : num;
    mag = (mag + (SCALE >>> 1)) >>> FRAC_BITS_DEF;
    if (mag > 3 * SCALE) mag = 3 * SCALE;
    if (num < 0) mag = -mag;
    return OUT_W'(mag);
  endfunction

  // Everything is sampled at the rising edge; the bench drives on the falling one.
  always @(posedge clk) begin
    gain_expect_t head;
    gain_expect_t pred;
    if (rst) begin
      for (int i = 0; i < NUM_SETS; i++) rule_row_q[i] = RULE_RESET[i];
      gain_expect_q.delete();
      errors = 0;
    end else begin
      // Returned result against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (gain_expect_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected result: gain %0d (raw %h)", $realtime,
                     $signed(m_tdata[OUT_W-1:0]), m_tdata);
        end else begin
          head = gain_expect_q.pop_front();
          if (m_tdata !== {1'b0, head.gain}) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("[%0t] gain mismatch: err %0d rate %0d expected %0d got %0d (raw %h)",
                       $realtime, $signed(head.err), $signed(head.rate),
                       $signed(head.gain), $signed(m_tdata[OUT_W-1:0]), m_tdata);
          end
        end
      end
      // Accepted request: predict with the rule table as it stands now.
      if (s_tvalid && s_tready) begin
        pred.err  = s_tdata[IN_W-1:0];
        pred.rate = s_tdata[2*IN_W-1:IN_W];
        pred.gain = blend_gain(pred.err, pred.rate);
        gain_expect_q.push_back(pred);
      end
      // Rule row writes; indexes past the last row are dropped.
      if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_SETS)
        rule_row_q[cfg_index] = cfg_data;
    end
    fail_count  <= errors;
    outstanding <= gain_expect_q.size();
  end

endmodule

// File: sim/tb.sv
// Top of the fuzzy gain scheduler bench: clock, reset, request and rule-row
// stimulus, receiver back-pressure and the final verdict.
// Depends on fgs_pkg, fuzzy_gain_scheduler_7x7 and fgs_checker.
`timescale 1ns / 1ps

module tb;
  import fgs_pkg::*;

  localparam int ONE = 1 << FRAC_BITS_DEF;
  localparam int IDX_UNUSED = NUM_SETS;
  localparam int PHASE_ITEMS = 230;
  localparam int NUM_PHASES = 6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [2*IN_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [OUT_W:0]       m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RULE_W-1:0]    cfg_data = '0;
  int                   fail_count;
  int                   outstanding;
  bit                   quiet = 1'b0;
  int                   stall_left = 0;

  always #2 clk = ~clk;

  fuzzy_gain_scheduler_7x7 dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fgs_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Idle length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = (stall_left == 0);
    end else begin
      stall_left = pick_gap();
      m_tready = (stall_left == 0);
    end
  end

  // Error or rate value: mostly inside the clamp range, with centres,
  // clamp edges and raw 16-bit patterns mixed in.
  function automatic logic [IN_W-1:0] pick_input();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1: return IN_W'($urandom);
      2: return IN_W'((int'($urandom_range(0, 6)) - 3) * ONE + int'($urandom_range(0, 6)) - 3);
      3: begin
        case ($urandom_range(0, 6))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return IN_W'(3 * ONE);
          3: return IN_W'(-3 * ONE);
          4: return IN_W'(3 * ONE + 1);
          5: return IN_W'(-3 * ONE - 1);
          default: return '0;
        endcase
      end
      default: return IN_W'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE);
    endcase
  endfunction

  // One request; entered and left on a falling edge.
  task automatic push_sample(input int err, input int rate);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {IN_W'(rate), IN_W'(err)};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold requests back until every predicted gain has come back.
  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_row(input int idx, input logic [RULE_W-1:0] row);
    cfg_valid = 1'b1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data  = row;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stimulus.
  initial begin
    logic [RULE_W-1:0] row;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests on the reset rule table: clamp edges, set centres,
    // half grades and rounding ties.
    quiet = 1'b1;
    push_sample(0, 0);
    push_sample(3 * ONE, 3 * ONE);
    push_sample(-3 * ONE, -3 * ONE);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    push_sample(32767, -32768);
    push_sample(3 * ONE + 1, -3 * ONE - 1);
    push_sample(ONE, -2 * ONE);
    push_sample(ONE / 2, -ONE / 2);
    push_sample(1, 1);
    push_sample(-1, -1);
    push_sample(3 * ONE - 1, -3 * ONE + 1);
    push_sample(-3 * ONE + 1, -3 * ONE + ONE / 2);
    push_sample(5000, -7000);
    push_sample(-ONE + 1, ONE - 1);
    push_sample(2 * ONE + 3, 0);
    quiet = 1'b0;

    // Random phases; each phase after the first rewrites the rule table first.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        for (int r = 0; r < NUM_SETS; r++) begin
          case (phase)
            1: row = '1;
            2: row = '0;
            NUM_PHASES - 1: row = RULE_RESET[r];
            default: row = RULE_W'($urandom);
          endcase
          write_row(r, row);
        end
        // The unused index must leave the table alone.
        write_row(IDX_UNUSED, RULE_W'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (phase % 2 == 1) && (n < 60);
        if ($urandom_range(0, 99) == 0) drain();
        push_sample(int'($signed(pick_input())), int'($signed(pick_input())));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (12) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("fuzzy_gain_scheduler_7x7 regression: pass");
    end else begin
      $display("fuzzy_gain_scheduler_7x7 regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("fuzzy_gain_scheduler_7x7 regression: fail");
    $finish;
  end

endmodule
